[sv/stcf_pkg.sv]
// Shared types, constants and register codes for the scrolled tilemap cell fetch.
`timescale 1ns / 1ps
`default_nettype none

package stcf_pkg;

  // Default geometry
  localparam int TileSizeDef = 32;
  localparam int MapRowsDef  = 64;
  localparam int MapColsDef  = 64;
  localparam int ViewRowsDef = 64;
  localparam int ViewColsDef = 64;
  localparam int MaxSetsDef  = 3;

  // Register file layout
  localparam int SetRegs      = 3;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int MaxSheetCols = 1024;
  localparam int DivSteps     = 16;

  localparam logic [CfgIdxW-1:0] REG_TILESET_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_ID0     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FIRST_ID1     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FIRST_ID2     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COLS0         = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COLS1         = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COLS2         = 3'd6;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  map_row;
    logic [5:0]  map_col;
    logic [15:0] tile_value;
    logic [5:0]  screen_row;
    logic [5:0]  screen_col;
    logic [11:0] scroll_x;
    logic [11:0] scroll_y;
  } stcf_item_t;

  typedef struct packed {
    logic               draw;
    logic               out_of_map;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [1:0]         set_index;
    logic [15:0]        sheet_row;
    logic [9:0]         sheet_col;
  } stcf_result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic rem;
    logic fix;
    logic rd;
    logic div_load;
    logic div_step;
    logic emit;
    logic emit_draw;
    logic write;
  } stcf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic view_miss;
    logic map_miss;
    logic id_zero;
    logic div_last;
  } stcf_status_t;

endpackage

`default_nettype wire

[sv/scrolled_tilemap_cell_fetch.sv]
// Top level of the scrolled tilemap cell fetch: controller, datapath and checks.
// For a write item, busy stays low and no result follows.
// A render item gives one result, strobed by done_o for one cycle: after the view and
// map check for a cell outside the view or the map, after the map read for an empty
// cell, and after the 16-step restoring divider (sheet row and column) when drawn.
// The receiver cannot stall; rst_ni clears control and the register file, not map memory.
`timescale 1ns / 1ps
`default_nettype none

module scrolled_tilemap_cell_fetch
  import stcf_pkg::*;
#(
  parameter int TILE_SIZE = TileSizeDef,
  parameter int MAP_ROWS  = MapRowsDef,
  parameter int MAP_COLS  = MapColsDef,
  parameter int VIEW_ROWS = ViewRowsDef,
  parameter int VIEW_COLS = ViewColsDef,
  parameter int MAX_SETS  = MaxSetsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire stcf_item_t          item_i,
  output logic                     done_o,
  output stcf_result_t             result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // An item is taken whenever start meets an idle block.
  logic         accept;
  stcf_cmd_t    cmd;
  stcf_status_t status;

  assign accept = start && !busy;

  // Controller: walks the scroll split, map read, tileset pick and divide.
  stcf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (item_i.mode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Datapath: holds the register file and the map memory, and builds the result.
  stcf_dpath #(
    .TILE_SIZE (TILE_SIZE),
    .MAP_ROWS  (MAP_ROWS),
    .MAP_COLS  (MAP_COLS),
    .VIEW_ROWS (VIEW_ROWS),
    .VIEW_COLS (VIEW_COLS),
    .MAX_SETS  (MAX_SETS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .result_o    (result_o)
  );

  // A result only ever closes a render that was in flight.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a render in flight");

  // One item, one strobe: never two results back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A render item must occupy the block.
  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.mode == MODE_RENDER)) |=> busy)
    else $error("render item accepted but block not busy");

  // A write item finishes at once and gives no result.
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.mode == MODE_WRITE)) |=> (!busy && !done_o))
    else $error("write item produced work or a result");

  // A drawn tile always lies inside the map.
  a_draw_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.draw) |-> !result_o.out_of_map)
    else $error("drawn tile flagged outside the map");

endmodule

`default_nettype wire

[sv/stcf_ctrl.sv]
// Sequencing state machine for the scrolled tilemap cell fetch.
`timescale 1ns / 1ps
`default_nettype none

module stcf_ctrl
  import stcf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic         mode_i,
  input  wire stcf_status_t status_i,
  output stcf_cmd_t         cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_FIX,
    S_CHECK,
    S_PICK,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept_i && (mode_i == MODE_RENDER)) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end else if (accept_i) begin
          cmd_o.write = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_REM;
      end
      S_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.view_miss || status_i.map_miss) begin
          cmd_o.emit = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_PICK;
        end
      end
      S_PICK: begin
        if (status_i.id_zero) begin
          cmd_o.emit = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_draw = 1'b1;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

[sv/stcf_dpath.sv]
// Datapath: register file, map memory, scroll split, tileset pick and sheet divider.
`timescale 1ns / 1ps
`default_nettype none

module stcf_dpath
  import stcf_pkg::*;
#(
  parameter int TILE_SIZE = TileSizeDef,
  parameter int MAP_ROWS  = MapRowsDef,
  parameter int MAP_COLS  = MapColsDef,
  parameter int VIEW_ROWS = ViewRowsDef,
  parameter int VIEW_COLS = ViewColsDef,
  parameter int MAX_SETS  = MaxSetsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire stcf_cmd_t           cmd_i,
  input  wire stcf_item_t          item_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output stcf_status_t             status_o,
  output stcf_result_t             result_o
);

  localparam int Depth     = MAP_ROWS * MAP_COLS;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FineW     = $clog2(TILE_SIZE);
  localparam int RecipSh   = 24;
  localparam int RecipW    = 24;
  localparam int Recip     = (1 << RecipSh) / TILE_SIZE;
  localparam int ProdW     = 12 + RecipW;
  localparam int CntW      = $clog2(DivSteps);

  // Register file
  logic [1:0]  tset_cnt_q;
  logic [15:0] first_q [SetRegs];
  logic [10:0] cols_q  [SetRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tset_cnt_q <= 2'd1;
      for (int i = 0; i < SetRegs; i++) begin
        first_q[i] <= 16'd1;
        cols_q[i]  <= 11'd1;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TILESET_COUNT: tset_cnt_q <= cfg_wdata_i[1:0];
        REG_FIRST_ID0:     first_q[0] <= cfg_wdata_i;
        REG_FIRST_ID1:     first_q[1] <= cfg_wdata_i;
        REG_FIRST_ID2:     first_q[2] <= cfg_wdata_i;
        REG_COLS0:         cols_q[0]  <= cfg_wdata_i[10:0];
        REG_COLS1:         cols_q[1]  <= cfg_wdata_i[10:0];
        REG_COLS2:         cols_q[2]  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // Render item and scroll split
  stcf_item_t       item_q;
  logic             view_miss_q;
  logic [ProdW-1:0] prod_x_q, prod_y_q;
  logic [11:0]      qx_q, qy_q;
  logic [FineW:0]   rx_q, ry_q;
  logic [11:0]      dest_x_q, dest_y_q;
  logic [12:0]      mrow_q, mcol_q;
  logic             map_miss_q;

  logic [11:0]      qx_est, qy_est;
  logic             ge_x, ge_y;
  logic [FineW-1:0] fine_x, fine_y;
  logic [11:0]      coarse_x, coarse_y;
  logic [12:0]      mrow_d, mcol_d;

  assign qx_est   = prod_x_q[RecipSh +: 12];
  assign qy_est   = prod_y_q[RecipSh +: 12];
  assign ge_x     = (32'(rx_q) >= TILE_SIZE);
  assign ge_y     = (32'(ry_q) >= TILE_SIZE);
  assign fine_x   = ge_x ? FineW'(32'(rx_q) - TILE_SIZE) : FineW'(rx_q);
  assign fine_y   = ge_y ? FineW'(32'(ry_q) - TILE_SIZE) : FineW'(ry_q);
  assign coarse_x = qx_q + 12'(ge_x);
  assign coarse_y = qy_q + 12'(ge_y);
  assign mrow_d   = 13'(item_q.screen_row) + 13'(coarse_y);
  assign mcol_d   = 13'(item_q.screen_col) + 13'(coarse_x);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q      <= item_i;
      view_miss_q <= (32'(item_i.screen_row) >= VIEW_ROWS) ||
                     (32'(item_i.screen_col) >= VIEW_COLS);
    end
    if (cmd_i.mul) begin
      prod_x_q <= ProdW'(item_q.scroll_x) * ProdW'(RecipW'(Recip));
      prod_y_q <= ProdW'(item_q.scroll_y) * ProdW'(RecipW'(Recip));
    end
    if (cmd_i.rem) begin
      qx_q <= qx_est;
      qy_q <= qy_est;
      rx_q <= (FineW + 1)'(32'(item_q.scroll_x) - 32'(qx_est) * TILE_SIZE);
      ry_q <= (FineW + 1)'(32'(item_q.scroll_y) - 32'(qy_est) * TILE_SIZE);
    end
    if (cmd_i.fix) begin
      dest_x_q   <= 12'(32'(item_q.screen_col) * TILE_SIZE) - 12'(fine_x);
      dest_y_q   <= 12'(32'(item_q.screen_row) * TILE_SIZE) - 12'(fine_y);
      mrow_q     <= mrow_d;
      mcol_q     <= mcol_d;
      map_miss_q <= (32'(mrow_d) >= MAP_ROWS) || (32'(mcol_d) >= MAP_COLS);
    end
  end

  // Map memory
  logic [15:0]      map_mem_q [Depth];
  logic [15:0]      id_q;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic             wr_ok;

  assign wr_ok   = (32'(item_i.map_row) < MAP_ROWS) && (32'(item_i.map_col) < MAP_COLS);
  assign wr_addr = AddrW'(32'(item_i.map_row) * MAP_COLS + 32'(item_i.map_col));
  assign rd_addr = AddrW'(32'(mrow_q) * MAP_COLS + 32'(mcol_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_ok) map_mem_q[wr_addr] <= item_i.tile_value;
    if (cmd_i.rd) id_q <= map_mem_q[rd_addr];
  end

  // Tileset pick
  logic [1:0]  n_sets, set_sel;
  logic        found;
  logic [15:0] local_id;
  logic [10:0] cols_raw, cols_sat;

  always_comb begin
    n_sets = (tset_cnt_q == 2'd0) ? 2'd1 : tset_cnt_q;
    if (32'(n_sets) > MAX_SETS) n_sets = 2'(MAX_SETS);
    set_sel = n_sets - 2'd1;
    found   = 1'b0;
    for (int i = 0; i < SetRegs - 1; i++) begin
      if (!found && (i + 1 < 32'(n_sets)) && (id_q >= first_q[i]) &&
          (id_q < first_q[i+1])) begin
        set_sel = 2'(i);
        found   = 1'b1;
      end
    end
  end

  assign local_id = id_q - first_q[set_sel];
  assign cols_raw = cols_q[set_sel];
  assign cols_sat = (cols_raw == 11'd0) ? 11'd1 :
                    (32'(cols_raw) > MaxSheetCols) ? 11'(MaxSheetCols) : cols_raw;

  // Restoring divider, one quotient bit a cycle
  logic [15:0]     quo_q;
  logic [10:0]     rem_q, divisor_q;
  logic [1:0]      set_q;
  logic [CntW-1:0] cnt_q;
  logic [11:0]     trial;
  logic            trial_ge;

  assign trial    = {rem_q, quo_q[15]};
  assign trial_ge = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q     <= local_id;
      rem_q     <= 11'd0;
      divisor_q <= cols_sat;
      set_q     <= set_sel;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[14:0], trial_ge};
      rem_q <= trial_ge ? 11'(trial - {1'b0, divisor_q}) : trial[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Result register
  stcf_result_t res_q, res_d;

  always_comb begin
    res_d = '0;
    if (!view_miss_q) begin
      res_d.dest_x     = $signed(dest_x_q);
      res_d.dest_y     = $signed(dest_y_q);
      res_d.out_of_map = map_miss_q;
      if (cmd_i.emit_draw) begin
        res_d.draw      = 1'b1;
        res_d.set_index = set_q;
        res_d.sheet_row = quo_q;
        res_d.sheet_col = rem_q[9:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) res_q <= res_d;
  end

  assign status_o.view_miss = view_miss_q;
  assign status_o.map_miss  = map_miss_q;
  assign status_o.id_zero   = (id_q == 16'd0);
  assign status_o.div_last  = (cnt_q == CntW'(DivSteps - 1));
  assign result_o           = res_q;

endmodule

`default_nettype wire
